// ===== rtl/core/sjpr_pkg.sv =====
// Constants and helper functions for the seeded jitter pixel remap unit.
package sjpr_pkg;

  // Frame seed hash
  localparam logic [31:0] SEED_MUL = 32'd2654435761;

  // Multiplicative congruential generator, modulus 2^31-1
  localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam logic [15:0] LCG_MUL = 16'd48271;

  // Draw to signed offset in [-1e6, 1e6]
  localparam logic [20:0]        DRAW_SPAN = 21'd2000001;
  localparam logic signed [21:0] DRAW_MID  = 22'sd1000000;

  // Reciprocal of DRAW_SPAN, 41 fraction bits
  localparam int unsigned         SPAN_SHIFT = 41;
  localparam logic [63:0]         SPAN_RECIP_FULL = (64'd1 << SPAN_SHIFT) / 64'd2000001;
  localparam logic [20:0]         SPAN_RECIP = SPAN_RECIP_FULL[20:0];

  // Scale denominator 256e6 = 2^11 * 125000, rounding half away from zero
  localparam logic [38:0]  SCALE_HALF = 39'd128000000;
  localparam int unsigned  SCALE_SHIFT = 11;
  localparam logic [16:0]  SCALE_ODD = 17'd125000;
  localparam int unsigned  ODD_SHIFT = 43;
  localparam logic [63:0]  ODD_RECIP_FULL = (64'd1 << ODD_SHIFT) / 64'd125000;
  localparam logic [26:0]  ODD_RECIP = ODD_RECIP_FULL[26:0];

  // Register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd4;

  // Register reset values
  localparam logic [12:0]        WIDTH_RST  = 13'd1920;
  localparam logic [12:0]        HEIGHT_RST = 13'd1080;
  localparam logic signed [17:0] AMP_RST    = 18'sd2048;
  localparam logic [31:0]        SEED_RST   = 32'd97;

  localparam int unsigned MAX_DIM_DEF = 4096;

  // x mod (2^31-1) for x < 2^47, result below the modulus
  function automatic logic [30:0] mod_mersenne(input logic [46:0] x);
    logic [31:0] s;
    s = {1'b0, x[30:0]} + {16'd0, x[46:31]};
    if (s >= {1'b0, LCG_MOD}) begin
      s = s - {1'b0, LCG_MOD};
    end
    return s[30:0];
  endfunction

endpackage

// ===== rtl/core/seeded_jitter_pixel_remap_unit.sv =====
// Per-frame shake address generator: pipelined seed hash, generator draws, scaled offsets.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   frame_number, out_x, out_y
//  m_axis    out  m_axis_tvalid/m_axis_tready   source_x, source_y (tuser: fill_white)
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item per clock while the skid register is empty; items pass through the pipeline stages into the output register.
// The chain of dependent multiplies (seed hash, two LCG steps, mod, scale) sets the depth.
// Reset clears all valid bits and loads register defaults; cfg is always ready.
// A full skid register behind the output holds the pipeline until m_axis_tready returns.
module seeded_jitter_pixel_remap_unit #(
  parameter int unsigned MAX_DIM = sjpr_pkg::MAX_DIM_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // frame_number[31:0], out_x[43:32], out_y[55:44]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // source_x[11:0], source_y[23:12]
  output logic        m_axis_tuser,   // fill_white[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sjpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NS = 15;
  localparam logic [14:0] MAX_DIM_C = 15'(MAX_DIM);

  // Configuration registers
  logic [12:0]        width_q, height_q;
  logic signed [17:0] amp_q [2];
  logic [31:0]        seed_term_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= sjpr_pkg::WIDTH_RST;
      height_q    <= sjpr_pkg::HEIGHT_RST;
      amp_q[0]    <= sjpr_pkg::AMP_RST;
      amp_q[1]    <= sjpr_pkg::AMP_RST;
      seed_term_q <= sjpr_pkg::SEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sjpr_pkg::REG_WIDTH:  width_q     <= cfg_data_i[12:0];
        sjpr_pkg::REG_HEIGHT: height_q    <= cfg_data_i[12:0];
        sjpr_pkg::REG_AMP_X:  amp_q[0]    <= $signed(cfg_data_i[17:0]);
        sjpr_pkg::REG_AMP_Y:  amp_q[1]    <= $signed(cfg_data_i[17:0]);
        sjpr_pkg::REG_SEED:   seed_term_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages move together unless the skid register is full
  logic          en;
  logic [NS:1]   v_q;
  logic          out_valid_q, skid_valid_q;

  assign en            = ~skid_valid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-1:1], s_axis_tvalid};
    end
  end

  // Coordinates ride along
  logic [11:0] x_q [1:NS];
  logic [11:0] y_q [1:NS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[1] <= s_axis_tdata[43:32];
      y_q[1] <= s_axis_tdata[55:44];
      for (int i = 2; i <= NS; i++) begin
        x_q[i] <= x_q[i-1];
        y_q[i] <= y_q[i-1];
      end
    end
  end

  // Stages 1..7: seed hash and the two generator steps
  logic [31:0] hash_q, seed_q;
  logic [30:0] g0_q, g1_q, g1_6_q;
  logic [46:0] p1_q, p2_q;
  logic [30:0] draw_q [2];

  logic [63:0] hash_prod;
  logic [31:0] seed_d;
  logic [30:0] g0_d;

  always_comb begin
    hash_prod = 64'(s_axis_tdata[31:0]) * 64'(sjpr_pkg::SEED_MUL);
    seed_d    = hash_q + seed_term_q + 32'd1;
    if (seed_d == 32'd0) begin
      seed_d = 32'd1;
    end
    g0_d = sjpr_pkg::mod_mersenne({15'd0, seed_q});
    if (g0_d == 31'd0) begin
      g0_d = 31'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hash_q    <= hash_prod[31:0];
      seed_q    <= seed_d;
      g0_q      <= g0_d;
      p1_q      <= 47'(g0_q) * 47'(sjpr_pkg::LCG_MUL);
      g1_q      <= sjpr_pkg::mod_mersenne(p1_q);
      p2_q      <= 47'(g1_q) * 47'(sjpr_pkg::LCG_MUL);
      g1_6_q    <= g1_q;
      draw_q[0] <= g1_6_q;
      draw_q[1] <= sjpr_pkg::mod_mersenne(p2_q);
    end
  end

  // Stages 8..15: two lanes, x from the first draw and y from the second
  logic [10:0]        qd_q   [2];
  logic [30:0]        draw8_q[2];
  logic [21:0]        rd_q   [2];
  logic signed [21:0] k_q    [2];
  logic signed [39:0] num_q  [2];
  logic               neg12_q[2], neg13_q[2], neg14_q[2];
  logic [27:0]        m_q    [2], m13_q[2];
  logic [9:0]         q2_q   [2], q2_14_q[2];
  logic [17:0]        r2_q   [2];
  logic signed [10:0] off_q  [2];

  logic [51:0]        span_prod [2];
  logic [31:0]        rem_full  [2];
  logic [21:0]        rd_fix    [2];
  logic [38:0]        mag       [2];
  logic [38:0]        mag_rnd   [2];
  logic [54:0]        odd_prod  [2];
  logic [27:0]        r2_full   [2];
  logic [10:0]        qmag      [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      span_prod[l] = 52'(draw_q[l]) * 52'(sjpr_pkg::SPAN_RECIP);
      rem_full[l]  = 32'(draw8_q[l]) - 32'(qd_q[l]) * 32'(sjpr_pkg::DRAW_SPAN);
      // estimate is at most one low, so one subtract finishes the mod
      rd_fix[l]    = (rd_q[l] >= 22'(sjpr_pkg::DRAW_SPAN)) ?
                     rd_q[l] - 22'(sjpr_pkg::DRAW_SPAN) : rd_q[l];
      mag[l]       = num_q[l][39] ? 39'(-num_q[l]) : 39'(num_q[l]);
      mag_rnd[l]   = (mag[l] + sjpr_pkg::SCALE_HALF) >> sjpr_pkg::SCALE_SHIFT;
      odd_prod[l]  = 55'(m_q[l]) * 55'(sjpr_pkg::ODD_RECIP);
      r2_full[l]   = m13_q[l] - 28'(q2_q[l]) * 28'(sjpr_pkg::SCALE_ODD);
      qmag[l]      = 11'(q2_14_q[l]) +
                     ((r2_q[l] >= 18'(sjpr_pkg::SCALE_ODD)) ? 11'd1 : 11'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        qd_q[l]    <= span_prod[l][51:41];
        draw8_q[l] <= draw_q[l];
        rd_q[l]    <= rem_full[l][21:0];
        k_q[l]     <= $signed(rd_fix[l]) - sjpr_pkg::DRAW_MID;
        num_q[l]   <= 40'(k_q[l]) * 40'(amp_q[l]);
        neg12_q[l] <= num_q[l][39];
        m_q[l]     <= mag_rnd[l][27:0];
        q2_q[l]    <= odd_prod[l][52:43];
        m13_q[l]   <= m_q[l];
        neg13_q[l] <= neg12_q[l];
        r2_q[l]    <= r2_full[l][17:0];
        q2_14_q[l] <= q2_q[l];
        neg14_q[l] <= neg13_q[l];
        off_q[l]   <= neg14_q[l] ? -$signed(qmag[l]) : $signed(qmag[l]);
      end
    end
  end

  // Bounds check and result
  logic [14:0]        wc, hc;
  logic signed [15:0] sx, sy;
  logic               white;
  logic [24:0]        res;

  always_comb begin
    wc = ({2'd0, width_q}  > MAX_DIM_C) ? MAX_DIM_C : {2'd0, width_q};
    hc = ({2'd0, height_q} > MAX_DIM_C) ? MAX_DIM_C : {2'd0, height_q};
    sx = $signed({4'd0, x_q[NS]}) - 16'(off_q[0]);
    sy = $signed({4'd0, y_q[NS]}) - 16'(off_q[1]);
    white = ({3'd0, x_q[NS]} >= wc) || ({3'd0, y_q[NS]} >= hc) ||
            (sx < 16'sd0) || (sx >= $signed({1'b0, wc})) ||
            (sy < 16'sd0) || (sy >= $signed({1'b0, hc}));
    res = white ? {1'b1, 24'd0} : {1'b0, sy[11:0], sx[11:0]};
  end

  // Output register with skid stage
  logic [24:0] out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= v_q[NS];
    end else if (v_q[NS]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q[23:0];
  assign m_axis_tuser  = out_q[24];

endmodule

// ===== dv/tb.sv =====
// Testbench for the seeded jitter pixel remap unit: directed table, random scan runs, scoreboard.
`timescale 1ns / 100ps

module tb;

  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam logic [63:0] GEN_MOD = 64'd2147483647;
  localparam logic [63:0] GEN_MUL = 64'd48271;
  localparam longint DRAW_RANGE = 2000001;
  localparam longint DRAW_CENTER = 1000000;
  localparam longint OFFSET_DEN = 256000000;
  localparam int DIM_CAP = sjpr_pkg::MAX_DIM_DEF;
  localparam logic [sjpr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [sjpr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 105;

  typedef struct packed {
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic        fill_white;
  } remap_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [sjpr_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                   data;
    logic [31:0]                   frame;
    logic [11:0]                   ox;
    logic [11:0]                   oy;
    bit                            typed;
    remap_t                        want;
  } stim_row_t;

  localparam remap_t WHITE = '{src_x: 12'd0, src_y: 12'd0, fill_white: 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // frame_number[31:0], out_x[43:32], out_y[55:44]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // source_x[11:0], source_y[23:12]
  logic        m_axis_tuser;        // fill_white[0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [sjpr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // shadow of the register file
  logic [12:0]        width_q = sjpr_pkg::WIDTH_RST;
  logic [12:0]        height_q = sjpr_pkg::HEIGHT_RST;
  logic signed [17:0] ampx_q = sjpr_pkg::AMP_RST;
  logic signed [17:0] ampy_q = sjpr_pkg::AMP_RST;
  logic [31:0]        seedterm_q = sjpr_pkg::SEED_RST;

  remap_t remap_expq[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  logic   hold_off = 1'b0;
  event   rx_hold_go;

  seeded_jitter_pixel_remap_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint jitter_offset(input longint draw, input longint amp);
    longint k, num, mag, q;
    k   = (draw % DRAW_RANGE) - DRAW_CENTER;
    num = k * amp;
    mag = (num < 0) ? -num : num;
    q   = (mag + OFFSET_DEN / 2) / OFFSET_DEN;
    return (num < 0) ? -q : q;
  endfunction

  function automatic remap_t predict_remap(input logic [31:0] frame, input logic [11:0] ox,
                                           input logic [11:0] oy);
    logic [31:0] seed;
    logic [63:0] g0, g1, g2;
    longint      w, h, sx, sy;
    remap_t      res;
    w    = (width_q > DIM_CAP) ? DIM_CAP : longint'(width_q);
    h    = (height_q > DIM_CAP) ? DIM_CAP : longint'(height_q);
    seed = frame * HASH_MUL + seedterm_q + 32'd1;
    if (seed == 32'd0) seed = 32'd1;
    g0 = {32'd0, seed} % GEN_MOD;
    if (g0 == 64'd0) g0 = 64'd1;
    g1 = (g0 * GEN_MUL) % GEN_MOD;
    g2 = (g1 * GEN_MUL) % GEN_MOD;
    sx = longint'(ox) - jitter_offset(longint'(g1), longint'(ampx_q));
    sy = longint'(oy) - jitter_offset(longint'(g2), longint'(ampy_q));
    if (longint'(ox) >= w || longint'(oy) >= h || sx < 0 || sx >= w || sy < 0 || sy >= h) begin
      res = WHITE;
    end else begin
      res = '{src_x: sx[11:0], src_y: sy[11:0], fill_white: 1'b0};
    end
    return res;
  endfunction

  // frame number that makes the hashed seed land on a chosen value
  function automatic logic [31:0] frame_for_seed(input logic [31:0] target,
                                                 input logic [31:0] term);
    logic [31:0] inv;
    inv = HASH_MUL;
    repeat (5) inv = inv * (32'd2 - HASH_MUL * inv);
    return (target - term - 32'd1) * inv;
  endfunction

  function automatic stim_row_t item_row(input logic [31:0] frame, input logic [11:0] ox,
                                         input logic [11:0] oy, input bit typed,
                                         input remap_t want);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, data: '0, frame: frame, ox: ox, oy: oy, typed: typed,
          want: want};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [sjpr_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [31:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, frame: '0, ox: '0, oy: '0, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic logic [12:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 13'd0;
    if (r < 10) return 13'($urandom_range(4097, 8191));
    if (r < 25) return 13'($urandom_range(1, 16));
    return 13'($urandom_range(1, 4096));
  endfunction

  function automatic logic [31:0] pick_amp();
    if ($urandom_range(99) < 10) return $urandom();
    return 32'($urandom_range(0, 131072)) - 32'd65536;
  endfunction

  // leaves valid high so writes can go back to back
  task automatic write_reg(input logic [sjpr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sjpr_pkg::REG_WIDTH:  width_q = data[12:0];
      sjpr_pkg::REG_HEIGHT: height_q = data[12:0];
      sjpr_pkg::REG_AMP_X:  ampx_q = data[17:0];
      sjpr_pkg::REG_AMP_Y:  ampy_q = data[17:0];
      sjpr_pkg::REG_SEED:   seedterm_q = data;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [31:0] frame, input logic [11:0] ox,
                            input logic [11:0] oy, input bit typed, input remap_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {oy, ox, frame};
    do @(posedge clk_i); while (!s_axis_tready);
    remap_expq.push_back(typed ? want : predict_remap(frame, ox, oy));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (remap_expq.size() != 0) @(posedge clk_i);
  endtask

  // result side: check the transfer seen at this edge, then pick the next ready
  initial begin : result_side
    remap_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (remap_expq.size() == 0) begin
          $error("unexpected result: source_x %0d source_y %0d fill_white %0d",
                 m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tuser);
          fail_count++;
        end else begin
          want = remap_expq.pop_front();
          if (m_axis_tdata[11:0] !== want.src_x) begin
            $error("source_x: expected %0d, got %0d", want.src_x, m_axis_tdata[11:0]);
            fail_count++;
          end
          if (m_axis_tdata[23:12] !== want.src_y) begin
            $error("source_y: expected %0d, got %0d", want.src_y, m_axis_tdata[23:12]);
            fail_count++;
          end
          if (m_axis_tuser !== want.fill_white) begin
            $error("fill_white: expected %0d, got %0d", want.fill_white, m_axis_tuser);
            fail_count++;
          end
        end
      end
      m_axis_tready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long output back-pressure so the pipeline fills and stalls its input
  initial begin : rx_hold
    @(rx_hold_go);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows[$];
    bit          cfg_open;
    int          sent, run_len, xlim, ylim, r;
    logic [31:0] frame;
    logic [11:0] px, py;
    logic [31:0] seeds[3];

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      item_row(32'h0000_0000, 12'd0, 12'd0, 1'b0, '0),
      item_row(32'hFFFF_FFFF, 12'd4095, 12'd4095, 1'b1, WHITE),
      item_row(32'h0000_0001, 12'd1920, 12'd0, 1'b1, WHITE),
      item_row(32'h8000_0000, 12'd0, 12'd1080, 1'b1, WHITE),
      item_row(32'h1234_5678, 12'd1919, 12'd1079, 1'b0, '0),
      // hashed seed of zero, and seeds that are multiples of the generator modulus
      item_row(frame_for_seed(32'h0000_0000, sjpr_pkg::SEED_RST), 12'd100, 12'd100, 1'b0, '0),
      item_row(frame_for_seed(32'h7FFF_FFFF, sjpr_pkg::SEED_RST), 12'd200, 12'd200, 1'b0, '0),
      item_row(frame_for_seed(32'hFFFF_FFFE, sjpr_pkg::SEED_RST), 12'd300, 12'd300, 1'b0, '0),
      cfg_row(sjpr_pkg::REG_AMP_X, 32'd0),
      cfg_row(sjpr_pkg::REG_AMP_Y, 32'd0),
      item_row(32'd5, 12'd0, 12'd0, 1'b1, '{12'd0, 12'd0, 1'b0}),
      item_row(32'd6, 12'd1919, 12'd1079, 1'b1, '{12'd1919, 12'd1079, 1'b0}),
      cfg_row(sjpr_pkg::REG_WIDTH, 32'd0),
      item_row(32'd7, 12'd0, 12'd0, 1'b1, WHITE),
      // oversize width is clamped; upper data bits of the amplitude are dropped
      cfg_row(sjpr_pkg::REG_WIDTH, 32'd8191),
      cfg_row(sjpr_pkg::REG_HEIGHT, 32'd4096),
      cfg_row(sjpr_pkg::REG_AMP_X, 32'd65536),
      cfg_row(sjpr_pkg::REG_AMP_Y, 32'hFFFF_0000),
      item_row(32'hDEAD_BEEF, 12'd4095, 12'd4095, 1'b0, '0),
      item_row(32'h0F0F_0F0F, 12'd0, 12'd0, 1'b0, '0),
      item_row(32'hF0F0_F0F0, 12'd2048, 12'd2048, 1'b0, '0),
      // raw 18-bit amplitudes beyond the nominal range
      cfg_row(sjpr_pkg::REG_AMP_X, 32'h0002_0000),
      cfg_row(sjpr_pkg::REG_AMP_Y, 32'h0001_FFFF),
      cfg_row(sjpr_pkg::REG_SEED, 32'hFFFF_FFFF),
      item_row(32'h5555_5555, 12'd2048, 12'd2048, 1'b0, '0),
      item_row(32'hAAAA_AAAA, 12'd4095, 12'd0, 1'b0, '0),
      cfg_row(sjpr_pkg::REG_WIDTH, 32'd1),
      cfg_row(sjpr_pkg::REG_HEIGHT, 32'd1),
      cfg_row(sjpr_pkg::REG_AMP_X, 32'd0),
      cfg_row(sjpr_pkg::REG_AMP_Y, 32'd0),
      item_row(32'd9, 12'd0, 12'd0, 1'b1, '{12'd0, 12'd0, 1'b0}),
      item_row(32'd9, 12'd1, 12'd0, 1'b1, WHITE),
      item_row(32'd9, 12'd0, 12'd1, 1'b1, WHITE),
      // writes to unmapped indexes must leave the registers alone
      cfg_row(REG_SPARE_LO, 32'd0),
      cfg_row(REG_SPARE_HI, 32'hFFFF_FFFF),
      item_row(32'd10, 12'd0, 12'd0, 1'b1, '{12'd0, 12'd0, 1'b0})
    };

    cfg_open = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          drain_results();
          cfg_open = 1'b1;
        end
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_pixel(dir_rows[i].frame, dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].typed,
                   dir_rows[i].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      if (p == 0) begin
        write_reg(sjpr_pkg::REG_WIDTH, 32'd1920);
        write_reg(sjpr_pkg::REG_HEIGHT, 32'd1080);
        write_reg(sjpr_pkg::REG_AMP_X, 32'd2048);
        write_reg(sjpr_pkg::REG_AMP_Y, 32'hFFFF_F800);
        write_reg(sjpr_pkg::REG_SEED, 32'd0);
      end else if (p == 1) begin
        write_reg(sjpr_pkg::REG_WIDTH, 32'd4096);
        write_reg(sjpr_pkg::REG_HEIGHT, 32'd4096);
        write_reg(sjpr_pkg::REG_AMP_X, 32'd65536);
        write_reg(sjpr_pkg::REG_AMP_Y, 32'hFFFF_0000);
        write_reg(sjpr_pkg::REG_SEED, 32'hFFFF_FFFF);
      end else if (p == 2) begin
        write_reg(sjpr_pkg::REG_WIDTH, 32'd1);
        write_reg(sjpr_pkg::REG_HEIGHT, 32'd4097);
        write_reg(sjpr_pkg::REG_AMP_X, 32'hFFFF_0000);
        write_reg(sjpr_pkg::REG_AMP_Y, 32'd65536);
        write_reg(sjpr_pkg::REG_SEED, $urandom());
      end else begin
        write_reg(sjpr_pkg::REG_WIDTH, {19'd0, pick_dim()});
        write_reg(sjpr_pkg::REG_HEIGHT, {19'd0, pick_dim()});
        write_reg(sjpr_pkg::REG_AMP_X, pick_amp());
        write_reg(sjpr_pkg::REG_AMP_Y, pick_amp());
        write_reg(sjpr_pkg::REG_SEED, $urandom());
      end
      cfg_valid_i <= 1'b0;
      if (p == 4) -> rx_hold_go;

      seeds = '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
      xlim = (width_q > DIM_CAP) ? DIM_CAP : int'(width_q);
      ylim = (height_q > DIM_CAP) ? DIM_CAP : int'(height_q);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 60) frame = $urandom();
        else if (r < 85) frame = 32'($urandom_range(0, 15));
        else frame = frame_for_seed(seeds[$urandom_range(0, 2)], seedterm_q);
        // a short scan-order run within one frame, sometimes starting off-image
        if ($urandom_range(99) < 15 || xlim == 0 || ylim == 0) begin
          px = 12'($urandom_range(0, 4095));
          py = 12'($urandom_range(0, 4095));
        end else begin
          px = 12'($urandom_range(0, xlim - 1));
          py = 12'($urandom_range(0, ylim - 1));
        end
        run_len = $urandom_range(1, 24);
        for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
          send_pixel(frame, px, py, 1'b0, '0);
          px = px + 12'd1;
          sent++;
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && remap_expq.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
